FILE: sv/efsc_pkg.sv
// ---------------------------------------------------------------------------
// efsc_pkg: shared types and constants of the event frame size checker
// Word record passed from classifier to sequencer, result record, codes.
// ---------------------------------------------------------------------------
package efsc_pkg;

   localparam logic [63:0] TAG_WORD        = 64'hBADC0FFEEBADCAFE;
   localparam logic [3:0]  HEAD_MAGIC      = 4'h5;
   localparam logic [3:0]  TRAIL_MAGIC     = 4'hA;
   localparam logic [23:0] ONE_BLOCK_LIMIT = 24'h0013FE;
   localparam logic [23:0] BLOCK_OFFSET    = 24'd1023;
   localparam logic [27:0] HEAD_WORDS      = 28'd2;
   localparam int          SIZE_W          = 24;
   localparam int          MID_DEPTH       = 4;
   localparam int          OUT_DEPTH       = 2;

   typedef enum logic [3:0] {
      PH_FIRST,
      PH_TAGLEN,
      PH_TAGHDR0,
      PH_VEND2,
      PH_VEND3,
      PH_VHDR0,
      PH_HDR1,
      PH_MODHDR,
      PH_PAYLOAD
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_UNKNOWN_FORMAT,
      ST_HEAD_MAGIC,
      ST_MODULE_COUNT,
      ST_DECL_LENGTH,
      ST_TRAIL_MAGIC,
      ST_TRAIL_LENGTH
   } status_type;

   typedef enum logic [1:0] {
      FMT_BARE,
      FMT_TAGGED,
      FMT_VENDOR
   } format_type;

   // classified stream word
   typedef struct packed {
      logic        tag_hit;
      logic [3:0]  magic;
      logic [3:0]  count;
      logic [23:0] size;
      logic [12:0] blocks;
      logic        hi_zero;
      logic [27:0] low28;
      logic [23:0] len24;
   } word_type;

   typedef struct packed {
      status_type  status;
      format_type  frame_format;
      logic [3:0]  module_count;
      logic [27:0] event_length;
      logic [12:0] block_count_max;
   } result_type;

endpackage

FILE: sv/efsc_fifo.sv
// ---------------------------------------------------------------------------
// efsc_fifo: small register queue
// Push/full on the write side, pop/empty on the read side, head shown.
// ---------------------------------------------------------------------------
module efsc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/efsc_front.sv
// ---------------------------------------------------------------------------
// efsc_front: word classifier
// Extracts magic, count, module size and block count from each stream word.
// ---------------------------------------------------------------------------
module efsc_front #(
   parameter int MODULE_SIZE_BITS = 24
) (
   input  logic [63:0]       data_word,
   output efsc_pkg::word_type rec
);

   logic [efsc_pkg::SIZE_W-1:0] size;
   logic [efsc_pkg::SIZE_W-1:0] over;

   always_comb begin
      size = '0;
      size[MODULE_SIZE_BITS-1:0] = data_word[32 +: MODULE_SIZE_BITS];
   end

   assign over = size - efsc_pkg::BLOCK_OFFSET;

   always_comb begin
      rec.tag_hit = (data_word == efsc_pkg::TAG_WORD);
      rec.magic   = data_word[63:60];
      rec.count   = data_word[55:52];
      rec.size    = size;
      // one block up to the limit, then one more per 4 Ki words past the offset
      if (size <= efsc_pkg::ONE_BLOCK_LIMIT) begin
         rec.blocks = 13'd1;
      end else begin
         rec.blocks = {1'b0, over[23:12]} + 13'd1;
      end
      rec.hi_zero = (data_word[63:28] == '0);
      rec.low28   = data_word[27:0];
      rec.len24   = data_word[55:32];
   end

endmodule

FILE: sv/efsc_back.sv
// ---------------------------------------------------------------------------
// efsc_back: event sequencer
// Walks the framing phases, sums module sizes and checks header and trailer.
// ---------------------------------------------------------------------------
module efsc_back #(
   parameter int MAX_MODULES = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  efsc_pkg::word_type     rec,
   input  logic                   rec_empty,
   output logic                   rec_pop,
   input  logic                   res_full,
   output logic                   res_push,
   output efsc_pkg::result_type   res
);

   localparam logic [3:0] MAX_CNT = 4'(MAX_MODULES);

   efsc_pkg::phase_type  phase_ff, phase_in;
   efsc_pkg::format_type fmt_ff, fmt_in;
   logic [3:0]  hdr_magic_ff, hdr_magic_in;
   logic        decl_hi_zero_ff, decl_hi_zero_in;
   logic [27:0] decl_low_ff, decl_low_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [3:0]  idx_ff, idx_in;
   logic [27:0] size_sum_ff, size_sum_in;
   logic [15:0] block_sum_ff, block_sum_in;
   logic [12:0] peak_ff, peak_in;
   logic [27:0] len_ff, len_in;
   logic [27:0] left_ff, left_in;

   logic        fire;
   logic [27:0] size_sum_new;
   logic [15:0] block_sum_new;
   logic [12:0] peak_new;
   logic [3:0]  idx_new;
   logic [27:0] len_calc;
   logic        last_mod;
   logic        hdr_bad;
   logic        cnt_bad;
   logic        decl_bad;
   logic        trailer;

   assign fire          = !rec_empty && !res_full;
   assign size_sum_new  = size_sum_ff + 28'(rec.size);
   assign block_sum_new = block_sum_ff + 16'(rec.blocks);
   assign peak_new      = (rec.blocks > peak_ff) ? rec.blocks : peak_ff;
   assign idx_new       = idx_ff + 4'd1;
   assign len_calc      = size_sum_new + 28'(block_sum_new) + {14'b0, peak_new, 1'b0}
                          + efsc_pkg::HEAD_WORDS;
   assign last_mod      = (idx_new == cnt_ff);
   assign hdr_bad       = (hdr_magic_ff != efsc_pkg::HEAD_MAGIC);
   assign cnt_bad       = (rec.count == 4'd0) || (rec.count > MAX_CNT);
   assign decl_bad      = (fmt_ff == efsc_pkg::FMT_TAGGED)
                          && !(decl_hi_zero_ff && (decl_low_ff == len_calc));
   assign trailer       = (left_ff <= 28'd1);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         case (phase_ff)
            efsc_pkg::PH_FIRST: begin
               if (rec.tag_hit) begin
                  phase_in = efsc_pkg::PH_TAGLEN;
               end else if (rec.magic == efsc_pkg::HEAD_MAGIC) begin
                  phase_in = efsc_pkg::PH_HDR1;
               end else begin
                  phase_in = efsc_pkg::PH_VEND2;
               end
            end
            efsc_pkg::PH_TAGLEN:  phase_in = efsc_pkg::PH_TAGHDR0;
            efsc_pkg::PH_TAGHDR0: phase_in = efsc_pkg::PH_HDR1;
            efsc_pkg::PH_VEND2:   phase_in = efsc_pkg::PH_VEND3;
            efsc_pkg::PH_VEND3:   phase_in = efsc_pkg::PH_VHDR0;
            efsc_pkg::PH_VHDR0:   phase_in = efsc_pkg::PH_HDR1;
            efsc_pkg::PH_HDR1: begin
               phase_in = (hdr_bad || cnt_bad) ? efsc_pkg::PH_FIRST : efsc_pkg::PH_MODHDR;
            end
            efsc_pkg::PH_MODHDR: begin
               if (last_mod) begin
                  phase_in = decl_bad ? efsc_pkg::PH_FIRST : efsc_pkg::PH_PAYLOAD;
               end
            end
            efsc_pkg::PH_PAYLOAD: begin
               if (trailer) begin
                  phase_in = efsc_pkg::PH_FIRST;
               end
            end
            default: phase_in = efsc_pkg::PH_FIRST;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      fmt_in          = fmt_ff;
      hdr_magic_in    = hdr_magic_ff;
      decl_hi_zero_in = decl_hi_zero_ff;
      decl_low_in     = decl_low_ff;
      cnt_in          = cnt_ff;
      idx_in          = idx_ff;
      size_sum_in     = size_sum_ff;
      block_sum_in    = block_sum_ff;
      peak_in         = peak_ff;
      len_in          = len_ff;
      left_in         = left_ff;
      rec_pop         = fire;
      res_push        = 1'b0;
      res.status          = efsc_pkg::ST_OK;
      res.frame_format    = fmt_ff;
      res.module_count    = cnt_ff;
      res.event_length    = len_ff;
      res.block_count_max = peak_ff;
      if (fire) begin
         case (phase_ff)
            efsc_pkg::PH_FIRST: begin
               hdr_magic_in    = rec.magic;
               decl_hi_zero_in = 1'b1;
               decl_low_in     = '0;
               cnt_in          = '0;
               idx_in          = '0;
               size_sum_in     = '0;
               block_sum_in    = '0;
               peak_in         = '0;
               len_in          = '0;
               left_in         = '0;
               if (rec.tag_hit) begin
                  fmt_in = efsc_pkg::FMT_TAGGED;
               end else if (rec.magic == efsc_pkg::HEAD_MAGIC) begin
                  fmt_in = efsc_pkg::FMT_BARE;
               end else begin
                  fmt_in = efsc_pkg::FMT_VENDOR;
               end
            end
            efsc_pkg::PH_TAGLEN: begin
               decl_hi_zero_in = rec.hi_zero;
               decl_low_in     = rec.low28;
            end
            efsc_pkg::PH_TAGHDR0, efsc_pkg::PH_VHDR0: begin
               hdr_magic_in = rec.magic;
            end
            efsc_pkg::PH_VEND2, efsc_pkg::PH_VEND3: begin
            end
            efsc_pkg::PH_HDR1: begin
               res.event_length    = '0;
               res.block_count_max = '0;
               if (hdr_bad) begin
                  res_push         = 1'b1;
                  res.module_count = '0;
                  res.status       = (fmt_ff == efsc_pkg::FMT_VENDOR) ?
                                     efsc_pkg::ST_UNKNOWN_FORMAT : efsc_pkg::ST_HEAD_MAGIC;
               end else if (cnt_bad) begin
                  res_push         = 1'b1;
                  res.module_count = rec.count;
                  res.status       = efsc_pkg::ST_MODULE_COUNT;
               end else begin
                  cnt_in = rec.count;
                  idx_in = '0;
               end
            end
            efsc_pkg::PH_MODHDR: begin
               size_sum_in  = size_sum_new;
               block_sum_in = block_sum_new;
               peak_in      = peak_new;
               idx_in       = idx_new;
               if (last_mod) begin
                  if (decl_bad) begin
                     res_push            = 1'b1;
                     res.status          = efsc_pkg::ST_DECL_LENGTH;
                     res.event_length    = len_calc;
                     res.block_count_max = peak_new;
                  end else begin
                     len_in  = len_calc;
                     left_in = len_calc - efsc_pkg::HEAD_WORDS - 28'(cnt_ff);
                  end
               end
            end
            efsc_pkg::PH_PAYLOAD: begin
               if (!trailer) begin
                  left_in = left_ff - 28'd1;
               end else begin
                  res_push = 1'b1;
                  if (rec.magic != efsc_pkg::TRAIL_MAGIC) begin
                     res.status = efsc_pkg::ST_TRAIL_MAGIC;
                  end else if (rec.len24 != len_ff[23:0]) begin
                     res.status = efsc_pkg::ST_TRAIL_LENGTH;
                  end else begin
                     res.status = efsc_pkg::ST_OK;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= efsc_pkg::PH_FIRST;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      fmt_ff          <= fmt_in;
      hdr_magic_ff    <= hdr_magic_in;
      decl_hi_zero_ff <= decl_hi_zero_in;
      decl_low_ff     <= decl_low_in;
      cnt_ff          <= cnt_in;
      idx_ff          <= idx_in;
      size_sum_ff     <= size_sum_in;
      block_sum_ff    <= block_sum_in;
      peak_ff         <= peak_in;
      len_ff          <= len_in;
      left_ff         <= left_in;
   end

endmodule

FILE: sv/event_frame_size_checker.sv
// ---------------------------------------------------------------------------
// event_frame_size_checker: framing and length check of an event word stream
// Classifies each 64-bit word, sequences the event and reports one status.
// ---------------------------------------------------------------------------
// Input channel: one stream word per item on req_data_word, taken at a clock
// edge with req_push high and req_full low. A classifier tags each word and
// drops it into a four-entry queue; the sequencer behind it walks the
// preamble, header, module headers, payload and trailer of each event.
// Result channel: one item per event, or per first error, waits in a
// two-entry output queue; the head is on the rsp_ ports while rsp_empty is
// low and leaves at an edge with rsp_pop high.
// Throughput: the sequencer retires one word per cycle while res_full is low.
// Path: the last word of an event is registered in the word queue, its result
// in the output queue, and the result then shows on the rsp_ ports.
// Reset: both queues empty and the sequencer waits for the first word of a
// new record.
// A stalled receiver first fills the output queue, which holds the
// sequencer, which fills the word queue and then raises req_full.
// ---------------------------------------------------------------------------
module event_frame_size_checker #(
   parameter int MAX_MODULES      = 12,
   parameter int MODULE_SIZE_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [63:0] req_data_word,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_frame_format,
   output logic [3:0]  rsp_module_count,
   output logic [27:0] rsp_event_length,
   output logic [12:0] rsp_block_count_max
);

   localparam int WORD_W = $bits(efsc_pkg::word_type);
   localparam int RES_W  = $bits(efsc_pkg::result_type);

   efsc_pkg::word_type   in_rec;
   efsc_pkg::word_type   mid_rec;
   logic [WORD_W-1:0]    mid_data;
   logic                 mid_empty;
   logic                 mid_pop;
   efsc_pkg::result_type res;
   efsc_pkg::result_type head;
   logic [RES_W-1:0]     head_data;
   logic                 res_full;
   logic                 res_push;

   efsc_front #(
      .MODULE_SIZE_BITS(MODULE_SIZE_BITS)
   ) u_front (
      .data_word (req_data_word),
      .rec       (in_rec)
   );

   efsc_fifo #(
      .WIDTH(WORD_W),
      .DEPTH(efsc_pkg::MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (in_rec),
      .full      (req_full),
      .pop       (mid_pop),
      .pop_data  (mid_data),
      .empty     (mid_empty)
   );

   assign mid_rec = mid_data;

   efsc_back #(
      .MAX_MODULES(MAX_MODULES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .rec       (mid_rec),
      .rec_empty (mid_empty),
      .rec_pop   (mid_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res       (res)
   );

   efsc_fifo #(
      .WIDTH(RES_W),
      .DEPTH(efsc_pkg::OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (head_data),
      .empty     (rsp_empty)
   );

   assign head                = head_data;
   assign rsp_status          = head.status;
   assign rsp_frame_format    = head.frame_format;
   assign rsp_module_count    = head.module_count;
   assign rsp_event_length    = head.event_length;
   assign rsp_block_count_max = head.block_count_max;

endmodule
